// ===== design/led_progress_bar_fader_core_assert.svh =====
// assertion macros for the led progress bar fader checker
`ifndef LED_PROGRESS_BAR_FADER_CORE_ASSERT_SVH
`define LED_PROGRESS_BAR_FADER_CORE_ASSERT_SVH

// clocked assertion, quiet during reset
`define LPBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define LPBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lpbf_pkg.sv =====
// types and constants of the led progress bar fader
package lpbf_pkg;

  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 1'd1;

  localparam logic [7:0] MODE_PROGRESS = 8'd0;
  localparam logic [7:0] TARGET_ALL   = 8'hFF;
  localparam logic [7:0] SOLID_TARGET = 8'd100;
  localparam logic [14:0] ROUND_BIAS  = 15'd50;
  localparam logic [15:0] PERCENT     = 16'd100;

  localparam int SCALE_W  = 15;
  localparam int NUM_W    = 24;
  localparam int SER_STEPS = 8;
  localparam int SER_CNT_W = 4;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV1  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_DIV2  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

// ===== design/lpbf_ser_mul.sv =====
// bit-serial shift-add multiplier, 16 x 8, one multiplier bit per cycle
module lpbf_ser_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [15:0]                 a,
  input  logic [7:0]                  b,
  output logic                        done,
  output logic [lpbf_pkg::NUM_W-1:0]  prod
);

  logic                           busy;
  logic [lpbf_pkg::SER_CNT_W-1:0] cnt;
  logic [lpbf_pkg::NUM_W-1:0]     mcand;
  logic [7:0]                     mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lpbf_pkg::SER_CNT_W'(lpbf_pkg::SER_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lpbf_pkg::SER_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= '0;
      mcand  <= lpbf_pkg::NUM_W'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ===== design/lpbf_ser_div.sv =====
// bit-serial restoring divider, 8-bit quotient, one quotient bit per cycle
module lpbf_ser_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lpbf_pkg::NUM_W-1:0]  dividend,
  input  logic [15:0]                 divisor,
  output logic                        done,
  output logic [7:0]                  quotient,
  output logic                        rem_nz
);

  logic                           busy;
  logic [lpbf_pkg::SER_CNT_W-1:0] cnt;
  logic [15:0]                    rem;
  logic [7:0]                     lo;
  logic [16:0]                    trial;
  logic [16:0]                    diff;
  logic                           ge;

  // upper dividend bits are known to be below the divisor
  assign trial  = {rem, lo[7]};
  assign ge     = trial >= {1'b0, divisor};
  assign diff   = trial - {1'b0, divisor};
  assign rem_nz = rem != 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lpbf_pkg::SER_CNT_W'(lpbf_pkg::SER_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lpbf_pkg::SER_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[23:8];
      lo       <= dividend[7:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[15:0] : trial[15:0];
      lo       <= lo << 1;
      quotient <= {quotient[6:0], ge};
    end
  end

endmodule

// ===== design/led_progress_bar_fader_core.sv =====
// top level of the led progress bar fader: command filter, fade state and frame output
// commands, ticks and unused requests: one transfer per cycle, taken in the idle state
// first led of a frame: fading runs the multiply, fade division and scale states, else only
// scale; progress mode then adds the percent division; then LED_COUNT led transfers
// follow, and the next input transfer can follow the last led in the cycle after it
// synchronous reset clears the fade state but for the fade value and lit count, and both configuration registers
module led_progress_bar_fader_core #(
  parameter int LED_COUNT = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [7:0]                      cmd_group,
  input  logic [7:0]                      cmd_target,
  input  logic [7:0]                      cmd_mode,
  input  logic [7:0]                      cmd_value,
  input  logic [7:0]                      cmd_red,
  input  logic [7:0]                      cmd_green,
  input  logic [7:0]                      cmd_blue,
  input  logic [15:0]                     cmd_fade_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      led_index,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic                            last
);

  localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

  lpbf_pkg::state_t state, state_next;

  logic [7:0]  own_group;
  logic [7:0]  device_id;
  logic        solid_mode;
  logic [7:0]  target_value;
  logic [7:0]  start_value;
  logic [7:0]  colour_red;
  logic [7:0]  colour_green;
  logic [7:0]  colour_blue;
  logic [15:0] fade_length;
  logic [15:0] elapsed_ms;

  logic [7:0]  eff;
  logic [7:0]  lit;
  logic [5:0]  idx;

  logic        in_xfer;
  logic        out_xfer;
  logic        cmd_hit;
  logic        fading;
  logic        down;
  logic [7:0]  delta;
  logic [7:0]  step;

  logic                        mul_start;
  logic                        mul_done;
  logic [lpbf_pkg::NUM_W-1:0]  prod;
  logic                        div_start;
  logic [lpbf_pkg::NUM_W-1:0]  div_dividend;
  logic [15:0]                 div_divisor;
  logic                        div_done;
  logic [7:0]                  quotient;
  logic                        rem_nz;
  logic [lpbf_pkg::SCALE_W-1:0] scaled;
  logic                        on;

  assign cfg_ready = 1'b1;
  assign in_ready  = state == lpbf_pkg::ST_IDLE;
  assign out_valid = state == lpbf_pkg::ST_EMIT;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign cmd_hit = (cmd_group == own_group) &&
                   ((cmd_target == lpbf_pkg::TARGET_ALL) || (cmd_target == device_id));
  assign fading  = (fade_length != 16'd0) && (elapsed_ms < fade_length);
  assign down    = target_value < start_value;
  assign delta   = down ? start_value - target_value : target_value - start_value;
  assign step    = quotient + 8'(rem_nz);

  assign scaled = lpbf_pkg::SCALE_W'(eff) * lpbf_pkg::SCALE_W'(LED_COUNT)
                + lpbf_pkg::ROUND_BIAS;

  assign mul_start = in_xfer && (req_type == lpbf_pkg::REQ_FRAME) && fading;
  assign div_start = ((state == lpbf_pkg::ST_MUL) && mul_done) ||
                     ((state == lpbf_pkg::ST_SCALE) && !solid_mode);

  // the divisor is held for the whole fade division
  always_comb begin
    if ((state == lpbf_pkg::ST_MUL) || (state == lpbf_pkg::ST_DIV1)) begin
      div_dividend = prod;
      div_divisor  = fade_length;
    end else begin
      div_dividend = lpbf_pkg::NUM_W'(scaled);
      div_divisor  = lpbf_pkg::PERCENT;
    end
  end

  lpbf_ser_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (elapsed_ms),
    .b     (delta),
    .done  (mul_done),
    .prod  (prod)
  );

  lpbf_ser_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient),
    .rem_nz   (rem_nz)
  );

  always_comb begin
    state_next = state;
    case (state)
      lpbf_pkg::ST_IDLE: begin
        if (in_xfer && (req_type == lpbf_pkg::REQ_FRAME)) begin
          state_next = fading ? lpbf_pkg::ST_MUL : lpbf_pkg::ST_SCALE;
        end
      end
      lpbf_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = lpbf_pkg::ST_DIV1;
        end
      end
      lpbf_pkg::ST_DIV1: begin
        if (div_done) begin
          state_next = lpbf_pkg::ST_SCALE;
        end
      end
      lpbf_pkg::ST_SCALE: begin
        state_next = solid_mode ? lpbf_pkg::ST_EMIT : lpbf_pkg::ST_DIV2;
      end
      lpbf_pkg::ST_DIV2: begin
        if (div_done) begin
          state_next = lpbf_pkg::ST_EMIT;
        end
      end
      lpbf_pkg::ST_EMIT: begin
        if (out_xfer && (idx == LAST_IDX)) begin
          state_next = lpbf_pkg::ST_IDLE;
        end
      end
      default: state_next = lpbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lpbf_pkg::ST_IDLE;
      own_group    <= '0;
      device_id    <= '0;
      solid_mode   <= 1'b0;
      target_value <= '0;
      start_value  <= '0;
      colour_red   <= '0;
      colour_green <= '0;
      colour_blue  <= '0;
      fade_length  <= '0;
      elapsed_ms   <= '0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lpbf_pkg::CFG_GROUP) begin
          own_group <= cfg_data;
        end
        if (cfg_index == lpbf_pkg::CFG_DEVICE) begin
          device_id <= cfg_data;
        end
      end
      if (in_xfer && (req_type == lpbf_pkg::REQ_CMD) && cmd_hit) begin
        solid_mode   <= cmd_mode != lpbf_pkg::MODE_PROGRESS;
        colour_red   <= cmd_red;
        colour_green <= cmd_green;
        colour_blue  <= cmd_blue;
        fade_length  <= cmd_fade_ms;
        elapsed_ms   <= '0;
        start_value  <= target_value;
        target_value <= (cmd_mode != lpbf_pkg::MODE_PROGRESS) ? lpbf_pkg::SOLID_TARGET
                                                               : cmd_value;
      end
      if (in_xfer && (req_type == lpbf_pkg::REQ_TICK) && (elapsed_ms < fade_length)) begin
        elapsed_ms <= elapsed_ms + 16'd1;
      end
      if (state == lpbf_pkg::ST_SCALE) begin
        idx <= '0;
      end else if (out_xfer) begin
        idx <= idx + 6'd1;
      end
    end
  end

  // fade value and lit count
  always_ff @(posedge clk) begin
    if (in_xfer && !fading) begin
      eff <= target_value;
    end else if ((state == lpbf_pkg::ST_DIV1) && div_done) begin
      eff <= down ? start_value - step : start_value + quotient;
    end
    if ((state == lpbf_pkg::ST_SCALE) && solid_mode) begin
      lit <= 8'(LED_COUNT);
    end else if ((state == lpbf_pkg::ST_DIV2) && div_done) begin
      lit <= quotient;
    end
  end

  assign on        = {2'b00, idx} < lit;
  assign led_index = idx;
  assign red       = on ? colour_red : 8'd0;
  assign green     = on ? colour_green : 8'd0;
  assign blue      = on ? colour_blue : 8'd0;
  assign last      = idx == LAST_IDX;

endmodule

// ===== design/lpbf_port_checker.sv =====
// port-level checker for the led progress bar fader and its bind
`include "led_progress_bar_fader_core_assert.svh"

module lpbf_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] led_index,
  input logic [7:0] red,
  input logic       last
);

  `LPBF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(led_index) && $stable(red), "stalled result changed")
  `LPBF_ASSERT(a_frame_no_gap, out_valid && out_ready && !last |=> out_valid, "gap inside a frame")
  `LPBF_ASSERT(a_idle_after_last, out_valid && out_ready && last |=> in_ready && !out_valid, "not idle after last led")
  `LPBF_ASSERT(a_frame_starts_at_zero, $rose(out_valid) |-> led_index == 6'd0, "frame does not start at led zero")
  `LPBF_ASSERT_ALWAYS(a_one_item, rst || !(out_valid && in_ready), "input taken while a frame is out")

endmodule

bind led_progress_bar_fader_core lpbf_port_checker u_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .led_index (led_index),
  .red       (red),
  .last      (last)
);
